FILE: sv/xds_pkg.sv
// Shared constants, codes and divider tables for the oscillator divider search.
`timescale 1ns / 1ps

package xds_pkg;

  // Field widths
  localparam int FREQ_W   = 39;
  localparam int WORD_W   = 24;
  localparam int STATUS_W = 2;

  // Shared arithmetic widths
  localparam int MUL_AW = 59;              // remainder, frequency
  localparam int MUL_BW = 11;              // HS * N1, up to 1408
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 103;             // 51-bit product shifted up by 52
  localparam int DIV_DW = 59;              // crystal value or calibration RFREQ
  localparam int RF_W   = 38;

  // Register reset values
  localparam logic [FREQ_W-1:0] CAL_FREQ_RST  = 39'd69120000000;
  localparam logic [WORD_W-1:0] CAL_WORD_RST  = 24'd10502824;
  localparam logic [WORD_W-1:0] CAL_RFLOW_RST = 24'd1198214;

  // Limits: crystal in Hz with 32 fraction bits, DCO in Hz Q.8
  localparam logic [63:0] XTAL_MIN = 64'd113900000 << 32;
  localparam logic [63:0] XTAL_MAX = 64'd114700000 << 32;
  localparam logic [MUL_PW-1:0] DCO_MIN = MUL_PW'(64'd1241600000000);
  localparam logic [MUL_PW-1:0] DCO_MAX = MUL_PW'(64'd1451520000000);

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_HS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_XTAL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_CAL_FREQ  = 2'd0;
  localparam logic [1:0] REG_CAL_WORD  = 2'd1;
  localparam logic [1:0] REG_CAL_RFLOW = 2'd2;

  localparam logic [2:0] HS_LAST = 3'd5;
  localparam logic [2:0] N1_LAST = 3'd7;

  // HS divider value for a code, zero for codes the part does not list
  function automatic logic [3:0] hs_code_div(input logic [2:0] code);
    logic [3:0] d;
    case (code)
      3'd0:    d = 4'd4;
      3'd1:    d = 4'd5;
      3'd2:    d = 4'd6;
      3'd3:    d = 4'd7;
      3'd5:    d = 4'd9;
      3'd7:    d = 4'd11;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

  // Search order: table index to HS code
  function automatic logic [2:0] hs_idx_code(input logic [2:0] idx);
    logic [2:0] c;
    case (idx)
      3'd0:    c = 3'd0;
      3'd1:    c = 3'd1;
      3'd2:    c = 3'd2;
      3'd3:    c = 3'd3;
      3'd4:    c = 3'd5;
      default: c = 3'd7;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/xds_mul.sv
// Shared registered multiplier for the divider search.
`timescale 1ns / 1ps

module xds_mul (
  input  logic                      clk,
  input  logic [xds_pkg::MUL_AW-1:0] a,
  input  logic [xds_pkg::MUL_BW-1:0] b,
  output logic [xds_pkg::MUL_PW-1:0] p
);
  import xds_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_PW'(a) * MUL_PW'(b);
  end

endmodule

FILE: sv/xds_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module xds_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [xds_pkg::DIV_NW-1:0] num,
  input  logic [xds_pkg::DIV_DW-1:0] den,
  output logic                      done,
  output logic [xds_pkg::DIV_NW-1:0] quot,
  output logic [xds_pkg::DIV_DW-1:0] rem
);
  import xds_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_DW:0]   sh;
  logic              ge;

  assign sh = {rem, quot[DIV_NW-1]};
  assign ge = sh >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(DIV_NW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (cnt != '0) begin
      quot <= {quot[DIV_NW-2:0], ge};
      rem  <= ge ? DIV_DW'(sh - {1'b0, den_q}) : sh[DIV_DW-1:0];
    end
  end

endmodule

FILE: sv/xo_divider_search.sv
// Top level: configuration registers, search sequencer and shared arithmetic units.
//
//  channel   direction  handshake                 payload
//  request   in         in_valid / in_stall       target_freq
//  result    out        out_valid / out_stall     dividers_word, rfreq_low, status
//  config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// A request takes a crystal derivation and then a sweep of 48 candidates, with a
// further division for each candidate whose DCO lies in range; each division runs
// through the bit-serial divider (103 steps).
// rst is synchronous and restores the factory calibration values.
// The block takes the next request while a finished result waits under out_stall.
`timescale 1ns / 1ps

module xo_divider_search (
  input  logic                          clk,
  input  logic                          rst,
  // request
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [xds_pkg::FREQ_W-1:0]    target_freq,
  // result
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [xds_pkg::WORD_W-1:0]    dividers_word,
  output logic [xds_pkg::WORD_W-1:0]    rfreq_low,
  output logic [xds_pkg::STATUS_W-1:0]  status,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  import xds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CAL_MUL, S_CAL_LOAD, S_CAL_WAIT, S_CAL_CHK,
    S_CAND_SET, S_CAND_MUL, S_CAND_RANGE, S_CAND_WAIT, S_CAND_CHK,
    S_ERR_A, S_ERR_B, S_ERR_CMP, S_NEXT, S_FINISH
  } state_t;

  state_t state;

  // Configuration registers
  logic [FREQ_W-1:0] cal_freq;
  logic [WORD_W-1:0] cal_word;
  logic [WORD_W-1:0] cal_rflow;

  // Working registers
  logic [FREQ_W-1:0]   tgt;
  logic [DIV_DW-1:0]   xtal;
  logic [2:0]          hs_idx;
  logic [2:0]          n1_sh;
  logic [MUL_BW-1:0]   cur_m;
  logic                found;
  logic [DIV_DW-1:0]   best_r;
  logic [MUL_BW-1:0]   best_m;
  logic [RF_W-1:0]     best_c;
  logic [2:0]          best_code;
  logic [6:0]          best_n1;
  logic [STATUS_W-1:0] res_status;
  logic [MUL_PW-1:0]   prod_a;

  // Shared unit operands
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;
  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quot;
  logic [DIV_DW-1:0] div_rem;

  logic [3:0]  hsc;
  logic [37:0] cal_rf;
  logic [3:0]  cand_hs;
  logic        wr_en;
  logic        dco_ok;

  assign hsc     = hs_code_div(cal_word[23:21]);
  assign cal_rf  = {cal_word[13:0], cal_rflow};
  assign cand_hs = hs_code_div(hs_idx_code(hs_idx));
  assign wr_en   = psel && penable && pwrite && pready;
  assign dco_ok  = mul_p >= DCO_MIN && mul_p <= DCO_MAX;

  assign pready   = 1'b1;
  assign in_stall = state != S_IDLE;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_freq  <= CAL_FREQ_RST;
      cal_word  <= CAL_WORD_RST;
      cal_rflow <= CAL_RFLOW_RST;
    end else if (wr_en) begin
      case (paddr[4:3])
        REG_CAL_FREQ:  cal_freq  <= pwdata[FREQ_W-1:0];
        REG_CAL_WORD:  cal_word  <= pwdata[WORD_W-1:0];
        REG_CAL_RFLOW: cal_rflow <= pwdata[WORD_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_CAL_FREQ:  prdata = 64'(cal_freq);
      REG_CAL_WORD:  prdata = 64'(cal_word);
      REG_CAL_RFLOW: prdata = 64'(cal_rflow);
      default:       prdata = '0;
    endcase
  end

  xds_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  xds_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Sequencer: crystal derivation, then HS-major, N1-minor candidate sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
      found     <= 1'b0;
    end else begin
      // kick the divider for the crystal and for each in-band candidate
      div_start <= (state == S_CAL_LOAD) || (state == S_CAND_RANGE && dco_ok);
      // raise on a new result, drop once the waiting one is taken
      if (state == S_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            tgt   <= target_freq;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          found <= 1'b0;
          mul_a <= MUL_AW'(cal_freq);
          mul_b <= MUL_BW'(hsc) * (MUL_BW'(cal_word[20:14]) + MUL_BW'(1));
          if (hsc == 4'd0) begin
            res_status <= ST_BAD_HS;
            state      <= S_FINISH;
          end else if (cal_rf == '0) begin
            res_status <= ST_XTAL;
            state      <= S_FINISH;
          end else begin
            state <= S_CAL_MUL;
          end
        end
        S_CAL_MUL: state <= S_CAL_LOAD;
        S_CAL_LOAD: begin
          // numerator = cal_freq * Mcal * 2^52
          div_num <= {mul_p[50:0], 52'd0};
          div_den <= DIV_DW'(cal_rf);
          state   <= S_CAL_WAIT;
        end
        S_CAL_WAIT: if (div_done) state <= S_CAL_CHK;
        S_CAL_CHK: begin
          if (div_quot[DIV_NW-1:64] != '0 || div_quot[63:0] < XTAL_MIN ||
              div_quot[63:0] > XTAL_MAX) begin
            res_status <= ST_XTAL;
            state      <= S_FINISH;
          end else begin
            xtal   <= div_quot[DIV_DW-1:0];
            hs_idx <= '0;
            n1_sh  <= '0;
            state  <= S_CAND_SET;
          end
        end
        S_CAND_SET: begin
          cur_m <= MUL_BW'({7'd0, cand_hs} << n1_sh);
          mul_a <= MUL_AW'(tgt);
          mul_b <= MUL_BW'({7'd0, cand_hs} << n1_sh);
          state <= S_CAND_MUL;
        end
        S_CAND_MUL: state <= S_CAND_RANGE;
        S_CAND_RANGE: begin
          // skip candidates whose DCO lies outside the band
          if (!dco_ok) begin
            state <= S_NEXT;
          end else begin
            div_num <= {mul_p[50:0], 52'd0};
            div_den <= xtal;
            state   <= S_CAND_WAIT;
          end
        end
        S_CAND_WAIT: if (div_done) state <= S_CAND_CHK;
        S_CAND_CHK: begin
          if (div_quot[DIV_NW-1:RF_W] != '0) begin
            state <= S_NEXT;
          end else if (found) begin
            mul_a <= div_rem;
            mul_b <= best_m;
            state <= S_ERR_A;
          end else begin
            state <= S_ERR_CMP;
          end
        end
        S_ERR_A: begin
          mul_a <= best_r;
          mul_b <= cur_m;
          state <= S_ERR_B;
        end
        S_ERR_B: begin
          prod_a <= mul_p;
          state  <= S_ERR_CMP;
        end
        S_ERR_CMP: begin
          // take when first found, or when r*best_m <= best_r*m (ties go later)
          if (!found || prod_a <= mul_p) begin
            found     <= 1'b1;
            best_r    <= div_rem;
            best_m    <= cur_m;
            best_c    <= div_quot[RF_W-1:0];
            best_code <= hs_idx_code(hs_idx);
            best_n1   <= 7'((8'd1 << n1_sh) - 8'd1);
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (n1_sh == N1_LAST) begin
            n1_sh <= '0;
            if (hs_idx == HS_LAST) begin
              res_status <= ST_NOMATCH;
              state      <= S_FINISH;
            end else begin
              hs_idx <= hs_idx + 3'd1;
              state  <= S_CAND_SET;
            end
          end else begin
            n1_sh <= n1_sh + 3'd1;
            state <= S_CAND_SET;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            if (found) begin
              status        <= ST_OK;
              dividers_word <= {best_code, best_n1, best_c[37:24]};
              rfreq_low     <= best_c[23:0];
            end else begin
              status        <= res_status;
              dividers_word <= '0;
              rfreq_low     <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/xds_checker.sv
// Port-level assertions for the divider search, bound to the top level.
`timescale 1ns / 1ps

module xds_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [xds_pkg::WORD_W-1:0]    dividers_word,
  input logic [xds_pkg::WORD_W-1:0]    rfreq_low,
  input logic [xds_pkg::STATUS_W-1:0]  status
);
  import xds_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("reset left a result or busy state");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken without going busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> dividers_word == '0 && rfreq_low == '0)
    else $error("failed status with nonzero payload");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(dividers_word) &&
    $stable(rfreq_low) && $stable(status))
    else $error("stalled result changed");

endmodule

bind xo_divider_search xds_checker u_xds_checker (.*);
